FILE: design/fqpd_pkg.sv
// Package for the FIFO queue with peek and dump.
// Request/result types, command and status codes, controller states and
// the controller-to-datapath command and status structs. No dependencies.
package fqpd_pkg;

    localparam int WordWidth = 32;

    // Command codes carried in request.command
    localparam logic [2:0] CMD_ENQUEUE = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE = 3'd1;
    localparam logic [2:0] CMD_PRINT   = 3'd2;
    localparam logic [2:0] CMD_SIZE    = 3'd3;
    localparam logic [2:0] CMD_EMPTY   = 3'd4;
    localparam logic [2:0] CMD_FRONT   = 3'd5;
    localparam logic [2:0] CMD_BACK    = 3'd6;

    // Status codes carried in result.status
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]                  command;
        logic signed [WordWidth-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic signed [WordWidth-1:0] result_value;
        logic [1:0]                  status;
        logic                        last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_OUT,
        S_PRINT_READ,
        S_PRINT_OUT
    } state_t;

    // Read address select for the entry memory
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_BACK,
        RD_PRINT_NEXT
    } rd_sel_t;

    // Source of the value loaded into the result register
    typedef enum logic [2:0] {
        SRC_MEM,
        SRC_FULL,
        SRC_EMPTY_NEG,
        SRC_PRINT_EMPTY,
        SRC_SIZE,
        SRC_EMPTY_FLAG
    } out_src_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        logic     print_start;
        logic     print_step;
        logic     ld_out;
        out_src_t out_src;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic print_final;
    } dp_stat_t;

endpackage

FILE: design/fifo_queue_with_peek_and_dump.sv
// FIFO queue of signed 32-bit words with peek, size and dump; top level.
// Enqueue gives a result only if the queue is full; size, empty and
// full/empty status results are valid the cycle after the request;
// dequeue/front/back/print words: registered memory read, then result reg.
// One request at a time: the next is taken the cycle after the final result.
// Async reset empties the queue; stored words are not cleared. Uses fqpd_pkg.
module fifo_queue_with_peek_and_dump #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               request_valid,
    output logic               request_stall,
    input  fqpd_pkg::request_t request,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output fqpd_pkg::result_t  result
);

    // Controller to datapath: one command word per cycle, status back.
    fqpd_pkg::dp_cmd_t  dp_cmd;
    fqpd_pkg::dp_stat_t dp_stat;

    // The controller holds request_stall high in every state but idle, so a
    // request is decoded against the queue state left by the previous one.
    fqpd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .command       (request.command),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .stat          (dp_stat),
        .cmd           (dp_cmd)
    );

    // Ring buffer and result register. The result register holds its value
    // while stalled; print walks the ring from head for the stored count.
    fqpd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .push_value (request.push_value),
        .stat       (dp_stat),
        .result     (result)
    );

endmodule

FILE: design/fqpd_dp.sv
// Datapath: entry memory, ring pointers, fill count, print cursor and the
// result register. Driven by fqpd_ctrl through fqpd_pkg::dp_cmd_t.
// Depends on fqpd_pkg.
module fqpd_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fqpd_pkg::dp_cmd_t                     cmd,
    input  logic signed [fqpd_pkg::WordWidth-1:0] push_value,
    output fqpd_pkg::dp_stat_t                    stat,
    output fqpd_pkg::result_t                     result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = fqpd_pkg::WordWidth;

    logic [WW-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] prem_reg, prem_next;
    logic [WW-1:0] rdata_reg;
    fqpd_pkg::result_t out_reg, out_next;
    logic [AW-1:0] raddr;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign stat.is_empty    = (count_reg == '0);
    assign stat.is_full     = (count_reg == CW'(DEPTH));
    assign stat.print_final = (prem_reg == CW'(1));

    always_comb
    begin
        case (cmd.rd_sel)
            fqpd_pkg::RD_HEAD:       raddr = head_reg;
            fqpd_pkg::RD_BACK:       raddr = ring_prev(tail_reg);
            fqpd_pkg::RD_PRINT_NEXT: raddr = ring_next(pidx_reg);
            default:                 raddr = head_reg;
        endcase
    end

    always_comb
    begin
        head_next  = cmd.pop  ? ring_next(head_reg) : head_reg;
        tail_next  = cmd.push ? ring_next(tail_reg) : tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        pidx_next = pidx_reg;
        prem_next = prem_reg;
        if (cmd.print_start)
        begin
            pidx_next = head_reg;
            prem_next = count_reg;
        end
        else if (cmd.print_step)
        begin
            pidx_next = ring_next(pidx_reg);
            prem_next = prem_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.ld_out)
        begin
            out_next.last = cmd.out_last;
            case (cmd.out_src)
                fqpd_pkg::SRC_MEM:
                begin
                    out_next.result_value = rdata_reg;
                    out_next.status       = fqpd_pkg::STATUS_OK;
                end
                fqpd_pkg::SRC_FULL:
                begin
                    out_next.result_value = '0;
                    out_next.status       = fqpd_pkg::STATUS_FULL;
                end
                fqpd_pkg::SRC_EMPTY_NEG:
                begin
                    out_next.result_value = '1;
                    out_next.status       = fqpd_pkg::STATUS_EMPTY;
                end
                fqpd_pkg::SRC_PRINT_EMPTY:
                begin
                    out_next.result_value = '0;
                    out_next.status       = fqpd_pkg::STATUS_EMPTY;
                end
                fqpd_pkg::SRC_SIZE:
                begin
                    out_next.result_value = WW'(count_reg);
                    out_next.status       = fqpd_pkg::STATUS_OK;
                end
                fqpd_pkg::SRC_EMPTY_FLAG:
                begin
                    out_next.result_value = WW'(stat.is_empty);
                    out_next.status       = fqpd_pkg::STATUS_OK;
                end
                default:
                begin
                    out_next.result_value = '0;
                    out_next.status       = fqpd_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            pidx_reg  <= '0;
            prem_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pidx_reg  <= pidx_next;
            prem_reg  <= prem_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign result = out_reg;

endmodule

FILE: design/fqpd_ctrl.sv
// Controller: request decode and sequencing of reads and the print stream.
// Drives fqpd_dp through fqpd_pkg::dp_cmd_t. Depends on fqpd_pkg.
module fqpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    input  logic [2:0]          command,
    output logic                request_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  fqpd_pkg::dp_stat_t  stat,
    output fqpd_pkg::dp_cmd_t   cmd
);

    fqpd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqpd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        request_stall = 1'b1;
        result_valid  = 1'b0;
        cmd           = '0;
        cmd.rd_sel    = fqpd_pkg::RD_HEAD;
        cmd.out_src   = fqpd_pkg::SRC_MEM;
        case (state_reg)
            fqpd_pkg::S_IDLE:
            begin
                request_stall = 1'b0;
                if (request_valid)
                begin
                    cmd.out_last = 1'b1;
                    case (command)
                        fqpd_pkg::CMD_ENQUEUE:
                        begin
                            if (stat.is_full)
                            begin
                                cmd.ld_out  = 1'b1;
                                cmd.out_src = fqpd_pkg::SRC_FULL;
                                state_next  = fqpd_pkg::S_OUT;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        fqpd_pkg::CMD_DEQUEUE,
                        fqpd_pkg::CMD_FRONT,
                        fqpd_pkg::CMD_BACK:
                        begin
                            if (stat.is_empty)
                            begin
                                cmd.ld_out  = 1'b1;
                                cmd.out_src = fqpd_pkg::SRC_EMPTY_NEG;
                                state_next  = fqpd_pkg::S_OUT;
                            end
                            else
                            begin
                                cmd.mem_rd = 1'b1;
                                cmd.pop    = (command == fqpd_pkg::CMD_DEQUEUE);
                                cmd.rd_sel = (command == fqpd_pkg::CMD_BACK) ?
                                             fqpd_pkg::RD_BACK : fqpd_pkg::RD_HEAD;
                                state_next = fqpd_pkg::S_READ;
                            end
                        end
                        fqpd_pkg::CMD_PRINT:
                        begin
                            if (stat.is_empty)
                            begin
                                cmd.ld_out  = 1'b1;
                                cmd.out_src = fqpd_pkg::SRC_PRINT_EMPTY;
                                state_next  = fqpd_pkg::S_OUT;
                            end
                            else
                            begin
                                cmd.mem_rd      = 1'b1;
                                cmd.print_start = 1'b1;
                                state_next      = fqpd_pkg::S_PRINT_READ;
                            end
                        end
                        fqpd_pkg::CMD_SIZE:
                        begin
                            cmd.ld_out  = 1'b1;
                            cmd.out_src = fqpd_pkg::SRC_SIZE;
                            state_next  = fqpd_pkg::S_OUT;
                        end
                        fqpd_pkg::CMD_EMPTY:
                        begin
                            cmd.ld_out  = 1'b1;
                            cmd.out_src = fqpd_pkg::SRC_EMPTY_FLAG;
                            state_next  = fqpd_pkg::S_OUT;
                        end
                        default:
                        begin
                            // unused code: dropped
                            state_next = fqpd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            fqpd_pkg::S_READ:
            begin
                cmd.ld_out   = 1'b1;
                cmd.out_last = 1'b1;
                state_next   = fqpd_pkg::S_OUT;
            end
            fqpd_pkg::S_OUT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    state_next = fqpd_pkg::S_IDLE;
                end
            end
            fqpd_pkg::S_PRINT_READ:
            begin
                cmd.ld_out   = 1'b1;
                cmd.out_last = stat.print_final;
                state_next   = fqpd_pkg::S_PRINT_OUT;
            end
            fqpd_pkg::S_PRINT_OUT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    if (stat.print_final)
                    begin
                        state_next = fqpd_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.mem_rd     = 1'b1;
                        cmd.rd_sel     = fqpd_pkg::RD_PRINT_NEXT;
                        cmd.print_step = 1'b1;
                        state_next     = fqpd_pkg::S_PRINT_READ;
                    end
                end
            end
            default:
            begin
                state_next = fqpd_pkg::S_IDLE;
            end
        endcase
    end

endmodule
